/* design/hcx_pkg.sv */
// Package: shared types and constants for the hash counter keystream XOR unit.
`default_nettype none
package hcx_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hcx_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } hcx_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // load working state and message schedule
    logic round;   // run one compression round
    logic finish;  // add initial hash, store keystream block
    logic take;    // accept input byte into output register, advance position
  } hcx_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_block;  // position is zero: a new block must be computed
    logic last_round;  // round counter at 63
  } hcx_sts_t;

  localparam logic [1:0] RegKey0 = 2'd0;
  localparam logic [1:0] RegKey1 = 2'd1;
  localparam logic [1:0] RegKey2 = 2'd2;
  localparam logic [1:0] RegKey3 = 2'd3;

  localparam logic [31:0] PadWord = 32'h8000_0000;
  localparam logic [31:0] LenWord = 32'd288;

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage
`default_nettype wire

/* design/hcx_datapath.sv */
// Datapath: key registers, SHA-256 round engine, keystream block and XOR output.
`default_nettype none
module hcx_datapath
  import hcx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire hcx_cmd_t    cmd,
  input  wire hcx_in_t     in_item,
  output hcx_sts_t         sts,
  output hcx_out_t         out_item
);

  logic [63:0] key [4];
  logic [4:0]  block_position;
  logic [31:0] block_counter;
  logic [63:0] keystream_block [4];
  logic [5:0]  round_cnt;
  logic [31:0] w [16];
  logic [31:0] s [8];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= '0; key[1] <= '0; key[2] <= '0; key[3] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegKey0: key[0] <= cfg_data;
        RegKey1: key[1] <= cfg_data;
        RegKey2: key[2] <= cfg_data;
        RegKey3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Round logic on the current state and schedule head
  logic [31:0] e, a, t1, t2, wn, s0w, s1w;
  always_comb begin
    e   = s[4];
    a   = s[0];
    t1  = s[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
        + ((e & s[5]) ^ (~e & s[6])) + RoundK[round_cnt] + w[0];
    t2  = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
        + ((a & s[1]) ^ (a & s[2]) ^ (s[1] & s[2]));
    s0w = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1w = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    wn  = w[0] + s0w + w[9] + s1w;
  end

  // Compression engine: schedule window and working variables
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 4; i++) begin
        w[2*i]   <= key[i][63:32];
        w[2*i+1] <= key[i][31:0];
      end
      w[8]  <= block_counter;
      w[9]  <= PadWord;
      for (int i = 10; i < 15; i++) w[i] <= '0;
      w[15] <= LenWord;
      for (int i = 0; i < 8; i++) s[i] <= init_h(3'(i));
      round_cnt <= '0;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      s[7] <= s[6]; s[6] <= s[5]; s[5] <= s[4]; s[4] <= s[3] + t1;
      s[3] <= s[2]; s[2] <= s[1]; s[1] <= s[0]; s[0] <= t1 + t2;
      round_cnt <= round_cnt + 6'd1;
    end
  end

  // Store finished digest (first 256 bits)
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int i = 0; i < 4; i++)
        keystream_block[i] <= {s[2*i] + init_h(3'(2*i)), s[2*i+1] + init_h(3'(2*i+1))};
    end
  end

  // Byte select, XOR and position tracking
  logic [63:0] ks_word;
  logic [7:0]  ks_byte;
  always_comb begin
    ks_word = keystream_block[block_position[4:3]];
    ks_byte = ks_word[8*(7 - block_position[2:0]) +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_position <= '0;
      block_counter  <= '0;
    end else if (cmd.take) begin
      if (in_item.last_byte) begin
        block_position <= '0;
        block_counter  <= '0;
      end else begin
        block_position <= block_position + 5'd1;
        if (block_position == 5'd31) block_counter <= block_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      out_item.out_byte <= in_item.data_byte ^ ks_byte;
      out_item.out_last <= in_item.last_byte;
    end
  end

  assign sts.need_block = (block_position == 5'd0);
  assign sts.last_round = (round_cnt == 6'd63);

endmodule
`default_nettype wire

/* design/hcx_ctrl.sv */
// Controller: sequences block generation, byte acceptance and output handshake.
`default_nettype none
module hcx_ctrl
  import hcx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire hcx_sts_t sts,
  output hcx_cmd_t      cmd
);

  typedef enum logic [1:0] {S_WAIT, S_ROUND, S_FINISH, S_READY} state_t;
  state_t state;
  logic   have_block;

  wire out_free = !out_valid || out_ready;
  assign in_ready   = (state == S_READY) && out_free;
  wire   take       = in_valid && in_ready;

  always_comb begin
    cmd.start  = (state == S_WAIT) && in_valid && sts.need_block;
    cmd.round  = (state == S_ROUND);
    cmd.finish = (state == S_FINISH);
    cmd.take   = take;
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WAIT;
      out_valid  <= 1'b0;
      have_block <= 1'b0;
    end else begin
      if (take) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_WAIT: begin
          if (in_valid) begin
            if (sts.need_block && !have_block) state <= S_ROUND;
            else state <= S_READY;
          end
        end
        S_ROUND:  if (sts.last_round) state <= S_FINISH;
        S_FINISH: begin
          state      <= S_READY;
          have_block <= 1'b1;
        end
        S_READY: begin
          if (take) begin
            state      <= S_WAIT;
            have_block <= 1'b0;
          end
        end
        default: state <= S_WAIT;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> state == S_READY) else $error("take outside ready");
  a_round_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && sts.last_round) |=> state == S_FINISH)
    else $error("round sequence broken");
  a_out_set: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> out_valid) else $error("result lost");
`endif

endmodule
`default_nettype wire

/* design/hash_counter_keystream_xor_unit.sv */
// Top level: SHA-256 counter-mode keystream XOR unit.
//
// Input requests (in_valid/in_ready, payload in_data) carry one message byte and
// a last flag. Each accepted request yields one result request on out_valid/
// out_ready (payload out_data): the byte XORed with the keystream, flag copied.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// the four 64-bit key words; it is always ready, and every 2-bit index selects
// a key word. Write keys only while idle.
// Keystream blocks are SHA-256 of key || 32-bit counter, one round a cycle.
// A byte at the start of a block passes through the wait state (load), the
// round, finish and accept states; other bytes pass only through the wait and
// accept states of the controller.
// The result sits in an output register from the cycle after acceptance; a new
// byte is accepted while it waits only if out_ready is high that cycle.
// Synchronous reset clears position, counter, keys and valid; afterwards the
// controller waits in its wait state for a new message, with in_ready low.
`default_nettype none
module hash_counter_keystream_xor_unit
  import hcx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire hcx_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output hcx_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  hcx_cmd_t cmd;
  hcx_sts_t sts;

  assign cfg_ready = 1'b1;

  hcx_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  hcx_datapath u_dp (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data, .cmd,
    .in_item(in_data), .sts, .out_item(out_data)
  );

endmodule
`default_nettype wire
